[hw/rtl/lto_pkg.sv]
`default_nettype none

package lto_pkg;

	// fixed field widths
	localparam int LUMA_W    = 8;
	localparam int SCALE_W   = 4;
	localparam int CODE_W    = 4;
	localparam int LEN_W     = 5;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int SCALE_MAX = 15;

	// scale multiples 1*s .. 8*s
	localparam int N_MUL = 8;
	localparam int MUL_W = 7;
	// font cell row and column indexes
	localparam int ROW_W = 3;
	localparam int COL_W = 3;
	localparam int FONT_ROWS = 7;
	localparam int FONT_COLS = 5;

	localparam logic [LUMA_W-1:0] LUMA_GLYPH = 8'd235;
	localparam logic [LUMA_W-1:0] LUMA_BOX   = 8'd32;

	localparam logic [CODE_W-1:0] CODE_DIGIT_MAX = 4'd9;
	localparam logic [CODE_W-1:0] CODE_COLON     = 4'd10;
	localparam logic [CODE_W-1:0] CODE_DOT       = 4'd11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X    = 3'd0,
		REG_ORIGIN_Y    = 3'd1,
		REG_GLYPH_SCALE = 3'd2,
		REG_TEXT_CODES  = 3'd3,
		REG_TEXT_LENGTH = 3'd4
	} lto_reg_e;

	// overlay on, and mul[k] = (k+1) * scale
	typedef struct packed {
		logic                           en;
		logic [N_MUL-1:0][MUL_W-1:0]    mul;
	} lto_scale_t;

	// 5x7 font: digits 0-9, colon, dot; bit 4 is the leftmost column
	localparam logic [FONT_COLS-1:0] FONT [0:11][0:6] = '{
		'{5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e},
		'{5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e},
		'{5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f},
		'{5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e},
		'{5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02},
		'{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e},
		'{5'h06, 5'h08, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e},
		'{5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
		'{5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e},
		'{5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h02, 5'h0c},
		'{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00},
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h0c}
	};

	// one font row; blanks and rows past the glyph are empty
	function automatic logic [FONT_COLS-1:0] font_row(input logic [CODE_W-1:0] code,
			input logic [ROW_W-1:0] row);
		logic [FONT_COLS-1:0] bits;
		bits = '0;
		if (code <= CODE_DOT && row < ROW_W'(FONT_ROWS)) begin
			bits = FONT[code][row];
		end
		return bits;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/luma_text_overlay.sv]
`default_nettype none

// Channel   Handshake             Payload
// in        in_valid / in_ready   pixel_x, pixel_y, luma_in
// out       out_valid / out_ready luma_out, pixel_x_out, pixel_y_out
// cfg       cfg_wr_en             cfg_index, cfg_data
//
// Four-stage pipeline, one pixel per cycle while out_ready does not stall it; out_valid is the stage 4 valid bit.
// Stage 1 registers the input, stage 2 does the box and font-row compares, stage 3
// the per-char column compares, stage 4 the font lookup and luma select.
// Per-character cursors are rebuilt from the registers in two stages after a write.
// Each stage takes a new item whenever it is empty or its item moves on, so bubbles
// close up under an output stall. Reset clears the valid bits and loads the
// register reset values.

module luma_text_overlay #(
	parameter int MAX_CHARS  = 16,
	parameter int COORD_BITS = 12
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [COORD_BITS-1:0]            pixel_x,
	input  wire logic [COORD_BITS-1:0]            pixel_y,
	input  wire logic [lto_pkg::LUMA_W-1:0]       luma_in,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [lto_pkg::LUMA_W-1:0]            luma_out,
	output logic [COORD_BITS-1:0]                 pixel_x_out,
	output logic [COORD_BITS-1:0]                 pixel_y_out,
	input  wire logic                             cfg_wr_en,
	input  wire logic [lto_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lto_pkg::CFG_W-1:0]        cfg_data
);
	import lto_pkg::*;

	localparam int XW = $clog2((1 << COORD_BITS) + 6 * SCALE_MAX * MAX_CHARS
		+ 2 * SCALE_MAX);

	logic [COORD_BITS-1:0]  origin_x;
	logic [COORD_BITS-1:0]  origin_y;
	logic [SCALE_W-1:0]     scale;
	lto_scale_t             scale_info;
	logic [XW-1:0]          box_w;
	logic [MAX_CHARS-1:0]   lane_on;
	logic [MAX_CHARS-1:0][CODE_W-1:0] codes;
	logic [MAX_CHARS-1:0][XW-1:0]     cursor;
	logic [MAX_CHARS-1:0]   lane_hit;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	logic [COORD_BITS-1:0]  px_s1, py_s1, px_s2, py_s2, px_s3, py_s3, px_s4, py_s4;
	logic [LUMA_W-1:0]      luma_s1, luma_s2, luma_s3, luma_s4;
	logic                   box_s2, box_s3;
	logic                   row_in_s2, row_in_s3;
	logic [ROW_W-1:0]       row_s2, row_s3;

	logic [XW-1:0]          px_sh, py_sh;
	logic                   box_d;
	logic signed [XW:0]     dy;
	logic [XW-1:0]          dy_mag;
	logic                   row_in_d;
	logic [ROW_W-1:0]       row_d;
	logic [LUMA_W-1:0]      luma_d;

	lto_cfg #(
		.MAX_CHARS  (MAX_CHARS),
		.COORD_BITS (COORD_BITS),
		.XW         (XW)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.origin_x   (origin_x),
		.origin_y   (origin_y),
		.scale      (scale),
		.scale_info (scale_info),
		.box_w      (box_w),
		.lane_on    (lane_on),
		.codes      (codes),
		.cursor     (cursor)
	);

	// stage readiness; a stage moves when empty or when the next one takes its item
	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			px_s1   <= pixel_x;
			py_s1   <= pixel_y;
			luma_s1 <= luma_in;
		end
	end

	// stage 2: background box and font row, shifted by one scale unit to stay unsigned
	always_comb begin
		px_sh = XW'(px_s1) + XW'(scale);
		py_sh = XW'(py_s1) + XW'(scale);
		box_d = scale_info.en
			&& (px_sh >= XW'(origin_x)) && (px_sh < XW'(origin_x) + box_w)
			&& (py_sh >= XW'(origin_y))
			&& (XW'(py_s1) < XW'(origin_y) + XW'(scale_info.mul[N_MUL-1]));
		dy = $signed({1'b0, XW'(py_s1)}) - $signed({1'b0, XW'(origin_y)});
		dy_mag = dy[XW-1:0];
		row_in_d = !dy[XW] && (dy_mag < XW'(scale_info.mul[FONT_ROWS-1]));
		row_d = '0;
		for (int k = 0; k < FONT_ROWS - 1; k++) begin
			row_d = row_d + ROW_W'(dy_mag >= XW'(scale_info.mul[k]));
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			px_s2     <= px_s1;
			py_s2     <= py_s1;
			luma_s2   <= luma_s1;
			box_s2    <= box_d;
			row_in_s2 <= row_in_d;
			row_s2    <= row_d;
		end
	end

	// stage 3: one lane per char holds the font column
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			px_s3     <= px_s2;
			py_s3     <= py_s2;
			luma_s3   <= luma_s2;
			box_s3    <= box_s2;
			row_in_s3 <= row_in_s2;
			row_s3    <= row_s2;
		end
	end

	for (genvar i = 0; i < MAX_CHARS; i++) begin : g_lane
		lto_lane #(
			.COORD_BITS (COORD_BITS),
			.XW         (XW)
		) u_lane (
			.clk        (clk),
			.load_s3    (ready_s3 && valid_s2),
			.px_s2      (px_s2),
			.cursor     (cursor[i]),
			.scale_info (scale_info),
			.code       (codes[i]),
			.lane_on    (lane_on[i]),
			.row_in_s3  (row_in_s3),
			.row_s3     (row_s3),
			.hit        (lane_hit[i])
		);
	end

	// stage 4: luma select into the output register
	always_comb begin
		if (scale_info.en && (|lane_hit)) begin
			luma_d = LUMA_GLYPH;
		end else if (box_s3) begin
			luma_d = LUMA_BOX;
		end else begin
			luma_d = luma_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			px_s4   <= px_s3;
			py_s4   <= py_s3;
			luma_s4 <= luma_d;
		end
	end

	assign out_valid   = valid_s4;
	assign luma_out    = luma_s4;
	assign pixel_x_out = px_s4;
	assign pixel_y_out = py_s4;

endmodule

`default_nettype wire

[hw/rtl/lto_cfg.sv]
`default_nettype none

module lto_cfg #(
	parameter int MAX_CHARS  = 16,
	parameter int COORD_BITS = 12,
	parameter int XW         = 13
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [lto_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [lto_pkg::CFG_W-1:0]              cfg_data,
	output logic [COORD_BITS-1:0]                       origin_x,
	output logic [COORD_BITS-1:0]                       origin_y,
	output logic [lto_pkg::SCALE_W-1:0]                 scale,
	output lto_pkg::lto_scale_t                         scale_info,
	output logic [XW-1:0]                               box_w,
	output logic [MAX_CHARS-1:0]                        lane_on,
	output logic [MAX_CHARS-1:0][lto_pkg::CODE_W-1:0]   codes,
	output logic [MAX_CHARS-1:0][XW-1:0]                cursor
);
	import lto_pkg::*;

	localparam int STEP_W = $clog2(6 * MAX_CHARS);
	localparam int WF_W   = $clog2(6 * MAX_CHARS + 3);
	localparam int BW_W   = WF_W + SCALE_W;

	logic [COORD_BITS-1:0]  origin_x_q;
	logic [COORD_BITS-1:0]  origin_y_q;
	logic [SCALE_W-1:0]     scale_q;
	logic [CFG_W-1:0]       codes_q;
	logic [LEN_W-1:0]       length_q;

	logic [LEN_W-1:0]       n_len;
	logic [WF_W-1:0]        width_units;
	logic [MAX_CHARS-1:0]   is_digit;
	logic [MAX_CHARS-1:0][STEP_W-1:0] step_d;
	lto_scale_t             scale_d;

	lto_scale_t             scale_info_q;
	logic [BW_W-1:0]        box_w_q;
	logic [MAX_CHARS-1:0]   lane_on_q;
	logic [MAX_CHARS-1:0][STEP_W-1:0] step_q;
	logic [MAX_CHARS-1:0][XW-1:0]     cursor_q;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= COORD_BITS'(24);
			origin_y_q <= COORD_BITS'(24);
			scale_q    <= SCALE_W'(4);
			codes_q    <= '0;
			length_q   <= '0;
		end else if (cfg_wr_en) begin
			case (lto_reg_e'(cfg_index))
				REG_ORIGIN_X:    origin_x_q <= cfg_data[COORD_BITS-1:0];
				REG_ORIGIN_Y:    origin_y_q <= cfg_data[COORD_BITS-1:0];
				REG_GLYPH_SCALE: scale_q    <= cfg_data[SCALE_W-1:0];
				REG_TEXT_CODES:  codes_q    <= cfg_data;
				REG_TEXT_LENGTH: length_q   <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// first derived stage: clamp length, scale multiples, box width, steps
	always_comb begin
		n_len = (length_q > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : length_q;
		width_units = WF_W'(n_len) * WF_W'(6) + WF_W'(2);
		scale_d.en = (scale_q != '0);
		for (int k = 0; k < N_MUL; k++) begin
			scale_d.mul[k] = MUL_W'(scale_q) * MUL_W'(k + 1);
		end
		for (int j = 0; j < MAX_CHARS; j++) begin
			is_digit[j] = (codes_q[CODE_W*j +: CODE_W] <= CODE_DIGIT_MAX);
		end
	end

	// cursor step of char i in scale units: 4 per char plus 2 per earlier digit
	for (genvar i = 0; i < MAX_CHARS; i++) begin : g_step
		localparam logic [MAX_CHARS-1:0] LOW_MASK = MAX_CHARS'((64'd1 << i) - 64'd1);
		assign step_d[i] = STEP_W'(4 * i)
			+ (STEP_W'($countones(is_digit & LOW_MASK)) << 1);
	end

	always_ff @(posedge clk) begin
		scale_info_q <= scale_d;
		box_w_q      <= BW_W'(scale_q) * BW_W'(width_units);
		step_q       <= step_d;
		for (int i = 0; i < MAX_CHARS; i++) begin
			lane_on_q[i] <= (n_len > LEN_W'(i));
		end
	end

	// second derived stage: absolute cursor of each char
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_CHARS; i++) begin
			cursor_q[i] <= XW'(origin_x_q) + XW'(scale_q) * XW'(step_q[i]);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_CHARS; i++) begin
			codes[i] = codes_q[CODE_W*i +: CODE_W];
		end
	end

	assign origin_x   = origin_x_q;
	assign origin_y   = origin_y_q;
	assign scale      = scale_q;
	assign scale_info = scale_info_q;
	assign box_w      = XW'(box_w_q);
	assign lane_on    = lane_on_q;
	assign cursor     = cursor_q;

endmodule

`default_nettype wire

[hw/rtl/lto_lane.sv]
`default_nettype none

module lto_lane #(
	parameter int COORD_BITS = 12,
	parameter int XW         = 13
) (
	input  wire logic                        clk,
	input  wire logic                        load_s3,
	input  wire logic [COORD_BITS-1:0]       px_s2,
	input  wire logic [XW-1:0]               cursor,
	input  wire lto_pkg::lto_scale_t         scale_info,
	input  wire logic [lto_pkg::CODE_W-1:0]  code,
	input  wire logic                        lane_on,
	input  wire logic                        row_in_s3,
	input  wire logic [lto_pkg::ROW_W-1:0]   row_s3,
	output logic                             hit
);
	import lto_pkg::*;

	logic signed [XW:0]  dx;
	logic [XW-1:0]       dx_mag;
	logic                col_in;
	logic [COL_W-1:0]    col;
	logic                col_in_s3;
	logic [COL_W-1:0]    col_s3;
	logic [FONT_COLS-1:0] bits;

	// column of the font cell under the pixel, relative to this char
	always_comb begin
		dx = $signed({1'b0, XW'(px_s2)}) - $signed({1'b0, cursor});
		dx_mag = dx[XW-1:0];
		col_in = !dx[XW] && (dx_mag < XW'(scale_info.mul[FONT_COLS-1]));
		col = '0;
		for (int k = 0; k < FONT_COLS - 1; k++) begin
			col = col + COL_W'(dx_mag >= XW'(scale_info.mul[k]));
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			col_in_s3 <= col_in;
			col_s3    <= col;
		end
	end

	// font lookup
	always_comb begin
		bits = font_row(code, row_s3);
		hit  = lane_on && col_in_s3 && row_in_s3 && bits[COL_W'(FONT_COLS - 1) - col_s3];
	end

endmodule

`default_nettype wire

[sim/lto_overlay_checker.sv]
`timescale 1ns / 100ps

// Watches the pixel channels and the register port, predicts the overlaid luma of
// every accepted pixel and compares each result with the oldest prediction.
module lto_overlay_checker #(
	parameter int MAX_CHARS  = 16,
	parameter int COORD_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [COORD_BITS-1:0]            pixel_x,
	input  logic [COORD_BITS-1:0]            pixel_y,
	input  logic [lto_pkg::LUMA_W-1:0]       luma_in,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [lto_pkg::LUMA_W-1:0]       luma_out,
	input  logic [COORD_BITS-1:0]            pixel_x_out,
	input  logic [COORD_BITS-1:0]            pixel_y_out,
	input  logic                             cfg_wr_en,
	input  logic [lto_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lto_pkg::CFG_W-1:0]        cfg_data,
	output int                               fail_count,
	output int                               pending_count
);
	import lto_pkg::*;

	localparam int ORIGIN_RESET = 24;
	localparam int SCALE_RESET  = 4;

	// 5x7 font, leftmost column in bit 4: digits, then colon, then dot
	localparam logic [FONT_COLS-1:0] GLYPH_ROWS [0:11][0:6] = '{
		'{5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e},
		'{5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e},
		'{5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f},
		'{5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e},
		'{5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02},
		'{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e},
		'{5'h06, 5'h08, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e},
		'{5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
		'{5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e},
		'{5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h02, 5'h0c},
		'{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00},
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h0c}
	};

	typedef struct packed {
		logic [LUMA_W-1:0]     luma;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} overlay_pixel_t;

	// shadow copies of the overlay registers
	logic [COORD_BITS-1:0] org_x;
	logic [COORD_BITS-1:0] org_y;
	logic [SCALE_W-1:0]    cell_size;
	logic [CFG_W-1:0]      char_codes;
	logic [LEN_W-1:0]      char_count;

	overlay_pixel_t expected_pixels[$];
	overlay_pixel_t want;
	int errors = 0;

	// luma after overlay for one pixel under the current register values
	function automatic logic [LUMA_W-1:0] overlay_luma(input int px, input int py,
			input logic [LUMA_W-1:0] luma_i);
		int s, n, i, cursor, dx, dy, box_x0, box_y0;
		logic [CODE_W-1:0] code;
		logic [FONT_COLS-1:0] row_bits;
		logic on_glyph;
		logic [LUMA_W-1:0] result;
		result = luma_i;
		s = int'(cell_size);
		n = (int'(char_count) > MAX_CHARS) ? MAX_CHARS : int'(char_count);
		if (s != 0) begin
			// box reaches one cell past the text on every side, one cell more on the right
			box_x0 = int'(org_x) - s;
			box_y0 = int'(org_y) - s;
			if (px >= box_x0 && px < box_x0 + (6 * n + 2) * s &&
					py >= box_y0 && py < box_y0 + 9 * s) begin
				result = LUMA_BOX;
			end
			on_glyph = 1'b0;
			cursor = int'(org_x);
			dy = py - int'(org_y);
			for (i = 0; i < n; i++) begin
				code = char_codes[CODE_W*i +: CODE_W];
				dx = px - cursor;
				// blanks only move the cursor
				if (code <= CODE_DOT && dx >= 0 && dy >= 0 &&
						dx < FONT_COLS * s && dy < FONT_ROWS * s) begin
					row_bits = GLYPH_ROWS[code][dy / s];
					if (row_bits[FONT_COLS - 1 - dx / s]) begin
						on_glyph = 1'b1;
					end
				end
				cursor += (code <= CODE_DIGIT_MAX) ? 6 * s : 4 * s;
			end
			if (on_glyph) begin
				result = LUMA_GLYPH;
			end
		end
		return result;
	endfunction

	task automatic compare_field(input string what, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x      = COORD_BITS'(ORIGIN_RESET);
			org_y      = COORD_BITS'(ORIGIN_RESET);
			cell_size  = SCALE_W'(SCALE_RESET);
			char_codes = '0;
			char_count = '0;
			expected_pixels.delete();
			pending_count <= 0;
			fail_count    <= 0;
		end else begin
			// results first, so a pixel taken at this edge is never matched here
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: luma_out expected no item, got %0d at (%0d, %0d)",
						$time, luma_out, pixel_x_out, pixel_y_out);
					errors++;
				end else begin
					want = expected_pixels.pop_front();
					compare_field("luma_out", 32'(want.luma), 32'(luma_out));
					compare_field("pixel_x_out", 32'(want.x), 32'(pixel_x_out));
					compare_field("pixel_y_out", 32'(want.y), 32'(pixel_y_out));
				end
			end
			if (in_valid && in_ready) begin
				want.luma = overlay_luma(int'(pixel_x), int'(pixel_y), luma_in);
				want.x    = pixel_x;
				want.y    = pixel_y;
				expected_pixels.insert(expected_pixels.size(), want);
			end
			// register writes; spare indexes are dropped
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_ORIGIN_X:    org_x      = cfg_data[COORD_BITS-1:0];
					REG_ORIGIN_Y:    org_y      = cfg_data[COORD_BITS-1:0];
					REG_GLYPH_SCALE: cell_size  = cfg_data[SCALE_W-1:0];
					REG_TEXT_CODES:  char_codes = cfg_data;
					REG_TEXT_LENGTH: char_count = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			pending_count <= expected_pixels.size();
			fail_count    <= errors;
		end
	end

endmodule

[sim/luma_text_overlay_tb.sv]
`timescale 1ns / 100ps

// Pixel stimulus for the text overlay: reset settings, a directed pass over every
// character code, then phases of fresh register settings with pixels aimed at the
// text box and some noise. Both sides idle in bursts; one phase holds the output.
module luma_text_overlay_tb;
	import lto_pkg::*;

	localparam int MAX_CHARS      = 16;
	localparam int COORD_BITS     = 12;
	localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
	localparam int LEN_LIMIT      = (1 << LEN_W) - 1;
	localparam int TOTAL_ITEMS    = 850;
	localparam int CALM_ITEMS     = 120;
	localparam int SETTLE_CYCLES  = 12;
	localparam int LONG_HOLD      = 300;
	localparam int PRESSURE_PHASE = 3;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [LUMA_W-1:0]     luma_in;
	logic                  out_valid;
	logic                  out_ready;
	logic [LUMA_W-1:0]     luma_out;
	logic [COORD_BITS-1:0] pixel_x_out;
	logic [COORD_BITS-1:0] pixel_y_out;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	int                    fail_count;
	int                    pending_count;

	int sent_items   = 0;
	int quiet_cycles = 0;
	bit tx_idles     = 1'b1;
	bit rx_idles     = 1'b1;
	bit hold_req     = 1'b0;

	// register values as last written, used to aim the pixels
	int cur_org_x = 24;
	int cur_org_y = 24;
	int cur_scale = 4;
	int cur_chars = 0;

	luma_text_overlay #(
		.MAX_CHARS  (MAX_CHARS),
		.COORD_BITS (COORD_BITS)
	) dut (.*);

	lto_overlay_checker #(
		.MAX_CHARS  (MAX_CHARS),
		.COORD_BITS (COORD_BITS)
	) checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: ready bursts, random stalls, one long hold on request
	initial begin
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (rx_idles && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_pixel(input int x, input int y, input int luma);
		if (tx_idles && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x  <= x[COORD_BITS-1:0];
		pixel_y  <= y[COORD_BITS-1:0];
		luma_in  <= luma[LUMA_W-1:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_items++;
	endtask

	// mostly inside or around the box, some on its edges, some anywhere
	task automatic send_random_pixel();
		int s, box_w, box_h, x0, y0, x, y;
		s = (cur_scale == 0) ? 4 : cur_scale;
		box_w = (6 * cur_chars + 2) * s;
		box_h = 9 * s;
		x0 = cur_org_x - s;
		y0 = cur_org_y - s;
		case ($urandom_range(0, 9))
			0: begin
				x = $urandom_range(0, COORD_MAX);
				y = $urandom_range(0, COORD_MAX);
			end
			1: begin
				x = ($urandom_range(0, 1) == 1) ? x0 - 1 + $urandom_range(0, 1)
					: x0 + box_w - $urandom_range(0, 1);
				y = ($urandom_range(0, 1) == 1) ? y0 - 1 + $urandom_range(0, 1)
					: y0 + box_h - $urandom_range(0, 1);
			end
			default: begin
				x = x0 - 2 + $urandom_range(0, box_w + 3);
				y = y0 - 2 + $urandom_range(0, box_h + 3);
			end
		endcase
		if (x < 0) x = 0;
		if (x > COORD_MAX) x = COORD_MAX;
		if (y < 0) y = 0;
		if (y > COORD_MAX) y = COORD_MAX;
		send_pixel(x, y, $urandom_range(0, 255));
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// random garbage above the register width half of the time
	function automatic logic [CFG_W-1:0] with_junk(input logic [CFG_W-1:0] value,
			input int width);
		logic [CFG_W-1:0] junk;
		junk = {$urandom, $urandom};
		junk = junk << width;
		return ($urandom_range(0, 1) == 1) ? (value | junk) : value;
	endfunction

	function automatic int pick_coord();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 40);
			1: return $urandom_range(COORD_MAX - 120, COORD_MAX);
			default: return $urandom_range(0, COORD_MAX);
		endcase
	endfunction

	// new register settings, written with the pipeline empty
	task automatic apply_config(input int ox, input int oy, input int sc,
			input logic [CFG_W-1:0] codes, input int len);
		drain_pipeline();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), {$urandom, $urandom});
		write_reg(REG_ORIGIN_X, with_junk(CFG_W'(ox), COORD_BITS));
		write_reg(REG_ORIGIN_Y, with_junk(CFG_W'(oy), COORD_BITS));
		write_reg(REG_GLYPH_SCALE, with_junk(CFG_W'(sc), SCALE_W));
		write_reg(REG_TEXT_CODES, codes);
		write_reg(REG_TEXT_LENGTH, with_junk(CFG_W'(len), LEN_W));
		write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), {$urandom, $urandom});
		cfg_wr_en <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		cur_org_x = ox;
		cur_org_y = oy;
		cur_scale = sc;
		cur_chars = (len > MAX_CHARS) ? MAX_CHARS : len;
	endtask

	initial begin
		int i, k, n, cursor, dy, phase, ox, oy, sc, len;
		logic [CFG_W-1:0] codes;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		pixel_x   <= '0;
		pixel_y   <= '0;
		luma_in   <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		// reset settings: empty text, box only
		for (k = 0; k < 12; k++) begin
			send_random_pixel();
		end

		// directed: all sixteen codes at scale 1, origin (10, 5), box 9..106 x 4..12
		apply_config(10, 5, 1, 64'hfedc_ba98_7654_3210, MAX_CHARS);
		send_pixel(0, 0, 0);
		send_pixel(COORD_MAX, COORD_MAX, 255);
		send_pixel(9, 4, 0);
		send_pixel(8, 4, 17);
		send_pixel(106, 12, 255);
		send_pixel(107, 12, 200);
		cursor = 10;
		for (i = 0; i < MAX_CHARS; i++) begin
			// a row where the middle column is lit for most glyphs
			if (i <= CODE_DIGIT_MAX) begin
				dy = 6;
			end else if (i == CODE_COLON) begin
				dy = 1;
			end else if (i == CODE_DOT) begin
				dy = 5;
			end else begin
				dy = 3;
			end
			send_pixel(cursor + 2, 5 + dy, $urandom_range(0, 255));
			cursor += (i <= CODE_DIGIT_MAX) ? 6 : 4;
		end

		// fixed corner settings first, then random ones
		for (phase = 0; sent_items < TOTAL_ITEMS; phase++) begin
			codes = {$urandom, $urandom};
			case (phase)
				// overlay off
				0: begin
					ox = 100; oy = 100; sc = 0; len = MAX_CHARS;
				end
				// empty text, box partly left of and above zero
				1: begin
					ox = 0; oy = 0; sc = SCALE_MAX; len = 0;
				end
				// oversized length counts as full
				2: begin
					ox = 300; oy = 40; sc = 2; len = LEN_LIMIT;
				end
				3: begin
					ox = COORD_MAX; oy = COORD_MAX; sc = SCALE_MAX; len = MAX_CHARS + 1;
				end
				4: begin
					ox = 7; oy = 3; sc = SCALE_MAX; len = MAX_CHARS;
				end
				5: begin
					ox = COORD_MAX; oy = 0; sc = 1; len = 1;
				end
				default: begin
					ox = pick_coord();
					oy = pick_coord();
					sc = $urandom_range(0, SCALE_MAX);
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, LEN_LIMIT)
						: $urandom_range(0, MAX_CHARS);
				end
			endcase
			apply_config(ox, oy, sc, codes, len);
			if (sent_items >= TOTAL_ITEMS - CALM_ITEMS) begin
				tx_idles = 1'b0;
				rx_idles = 1'b0;
			end else begin
				tx_idles = ($urandom_range(0, 4) != 0);
				rx_idles = ($urandom_range(0, 4) != 0);
			end
			n = $urandom_range(25, 50);
			// output held off while pixels keep coming, so the pipe backs up
			if (phase == PRESSURE_PHASE) begin
				tx_idles = 1'b0;
				hold_req = 1'b1;
				n = 80;
			end
			for (k = 0; k < n; k++) begin
				send_random_pixel();
			end
		end

		drain_pipeline();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/lto_pkg.sv
hw/rtl/lto_cfg.sv
hw/rtl/lto_lane.sv
hw/rtl/luma_text_overlay.sv
sim/lto_overlay_checker.sv
sim/luma_text_overlay_tb.sv
